/* sv/nosc_pkg.sv */
// shared types, constants and helpers of the natural order string compare block
package nosc_pkg;

  localparam int unsigned MaxLenDefault = 256;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDot  = 8'h2e;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowZ = 8'h7a;
  localparam logic [7:0] CaseStep = 8'h20;

  localparam logic signed [1:0] OrderBefore = -2'sd1;
  localparam logic signed [1:0] OrderEqual  = 2'sd0;
  localparam logic signed [1:0] OrderAfter  = 2'sd1;

  typedef enum logic [1:0] {
    CmdAppendFirst  = 2'd0,
    CmdAppendSecond = 2'd1,
    CmdCompare      = 2'd2,
    CmdNone         = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OpAppendFirst  = 2'd0,
    OpAppendSecond = 2'd1,
    OpCompare      = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic       ignore_case;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              numerically_equal;
    logic              truncated;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic       fold;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  typedef enum logic [3:0] {
    StIdle,
    StScanAddr,
    StScanData,
    StDecide,
    StCmpAddr,
    StCmpData,
    StPost,
    StDone
  } state_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if ((c >= CharLowA) && (c <= CharLowZ)) begin
      return c - CaseStep;
    end
    return c;
  endfunction

endpackage

/* sv/nosc_ram.sv */
// generic single write port ram with one registered read port
module nosc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/nosc_front.sv */
// front end: accepts items, decodes the command and queues jobs for the engine
module nosc_front import nosc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output job_chan_t job_o,
  input  logic      job_ready_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            keep;
  logic            wr_en, rd_en;
  job_t            job_new;

  // decode the command, unused codes are dropped
  always_comb begin
    job_new.char_code = in_item_i.char_code;
    job_new.fold      = in_item_i.ignore_case;
    job_new.op        = OpCompare;
    keep              = 1'b1;
    unique case (cmd_e'(in_item_i.cmd))
      CmdAppendFirst:  job_new.op = OpAppendFirst;
      CmdAppendSecond: job_new.op = OpAppendSecond;
      CmdCompare:      job_new.op = OpCompare;
      default:         keep = 1'b0;
    endcase
  end

  assign full        = (count_q == CntW'(QueueDepth));
  assign wr_en       = push && !full && keep;
  assign job_o.valid = (count_q != '0);
  assign job_o.job   = mem_q[rd_ptr_q];
  assign rd_en       = job_o.valid && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(wr_en) - CntW'(rd_en);
    end
  end

endmodule

/* sv/nosc_back.sv */
// back end: string stores, segment scanner, compare sequencer and result register
module nosc_back import nosc_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      split_i,
  input  job_chan_t job_i,
  output logic      job_ready_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam int unsigned LenW  = $clog2(MaxLen + 1);
  localparam logic [LenW-1:0] MaxLenL = LenW'(MaxLen);

  state_e state_q, state_d;

  logic [LenW-1:0] len_q [2];
  logic [LenW-1:0] len_d [2];
  logic            ovf_q, ovf_d;
  logic            fold_q, fold_d;

  logic [LenW-1:0] pos_q [2];
  logic [LenW-1:0] pos_d [2];
  logic [LenW-1:0] cur_q [2];
  logic [LenW-1:0] cur_d [2];
  logic [LenW-1:0] sig_q [2];
  logic [LenW-1:0] sig_d [2];
  logic [LenW-1:0] ca_q [2];
  logic [LenW-1:0] ca_d [2];
  logic [1:0]      hsig_q, hsig_d, text_q, text_d, first_q, first_d, sdone_q, sdone_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic            tmode_q, tmode_d;
  logic signed [1:0] res_q, res_d, hint_q, hint_d;
  logic            numeq_q, numeq_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic [7:0]      rdata [2];
  logic [AddrW-1:0] raddr [2];
  logic [1:0]      we;

  // per string conditions
  logic [1:0]      at_end, dig, dotc, belongs;
  logic [LenW-1:0] seg_len [2];
  logic [LenW-1:0] sig_len [2];
  logic [7:0]      cx, cy;
  logic            differ, txt_pair, both_end, out_free, is_cmp;

  for (genvar k = 0; k < 2; k++) begin : g_str
    nosc_ram #(.Width(8), .Depth(MaxLen)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (len_q[k][AddrW-1:0]),
      .wdata_i (job_i.job.char_code),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
    assign raddr[k]   = (state_q == StScanAddr) ? cur_q[k][AddrW-1:0] : ca_q[k][AddrW-1:0];
    assign at_end[k]  = (cur_q[k] >= len_q[k]);
    assign dig[k]     = is_digit(rdata[k]);
    assign dotc[k]    = split_i && (rdata[k] == CharDot);
    assign belongs[k] = text_q[k] ? (!dig[k] && !dotc[k]) : dig[k];
    assign seg_len[k] = cur_q[k] - pos_q[k];
    assign sig_len[k] = cur_q[k] - sig_q[k];
  end

  assign is_cmp      = (job_i.job.op == OpCompare);
  assign job_ready_o = (state_q == StIdle);
  assign cx          = (fold_q && tmode_q) ? fold_upper(rdata[0]) : rdata[0];
  assign cy          = (fold_q && tmode_q) ? fold_upper(rdata[1]) : rdata[1];
  assign differ      = (cx != cy);
  assign txt_pair    = text_q[0] || text_q[1];
  assign both_end    = at_end[0] && at_end[1];
  assign out_free    = !out_valid_q || pop;
  assign empty       = !out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    we = 2'b00;
    if ((state_q == StIdle) && job_i.valid) begin
      we[0] = (job_i.job.op == OpAppendFirst)  && (len_q[0] < MaxLenL);
      we[1] = (job_i.job.op == OpAppendSecond) && (len_q[1] < MaxLenL);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (job_i.valid && is_cmp) state_d = StScanAddr;
      end
      StScanAddr: state_d = (&sdone_d) ? StDecide : StScanData;
      StScanData: state_d = StScanAddr;
      StDecide: begin
        if (txt_pair) begin
          state_d = StCmpAddr;
        end else if (hsig_q[0] != hsig_q[1]) begin
          state_d = StDone;
        end else if (hsig_q[0] && (sig_len[0] != sig_len[1])) begin
          state_d = StDone;
        end else if (hsig_q[0]) begin
          state_d = StCmpAddr;
        end else begin
          state_d = StPost;
        end
      end
      StCmpAddr: state_d = (cnt_q == '0) ? StPost : StCmpData;
      StCmpData: state_d = differ ? StDone : StCmpAddr;
      StPost: begin
        if (tmode_q && (seg_len[0] != seg_len[1])) begin
          state_d = StDone;
        end else if (both_end) begin
          state_d = StDone;
        end else begin
          state_d = StScanAddr;
        end
      end
      StDone: state_d = out_free ? StIdle : StDone;
      default: state_d = StIdle;
    endcase
  end

  // datapath
  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    fold_d      = fold_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    sig_d       = sig_q;
    ca_d        = ca_q;
    hsig_d      = hsig_q;
    text_d      = text_q;
    first_d     = first_q;
    sdone_d     = sdone_q;
    cnt_d       = cnt_q;
    tmode_d     = tmode_q;
    res_d       = res_q;
    hint_d      = hint_q;
    numeq_d     = numeq_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (job_i.valid) begin
          if (is_cmp) begin
            fold_d  = job_i.job.fold;
            hint_d  = OrderEqual;
            numeq_d = 1'b0;
            for (int k = 0; k < 2; k++) begin
              pos_d[k] = '0;
              cur_d[k] = '0;
            end
            first_d = 2'b11;
            hsig_d  = 2'b00;
            sdone_d = 2'b00;
          end else begin
            for (int k = 0; k < 2; k++) begin
              if (job_i.job.op == op_e'(k)) begin
                if (len_q[k] < MaxLenL) len_d[k] = len_q[k] + 1'b1;
                else ovf_d = 1'b1;
              end
            end
          end
        end
      end
      StScanAddr: begin
        for (int k = 0; k < 2; k++) begin
          if (!sdone_q[k] && at_end[k]) begin
            sdone_d[k] = 1'b1;
            if (first_q[k]) text_d[k] = 1'b1;
          end
        end
      end
      StScanData: begin
        for (int k = 0; k < 2; k++) begin
          if (!sdone_q[k]) begin
            if (first_q[k] || belongs[k]) begin
              first_d[k] = 1'b0;
              if (first_q[k]) text_d[k] = !dig[k];
              cur_d[k] = cur_q[k] + 1'b1;
              // a lone dot is a segment of its own
              if (first_q[k] && dotc[k]) sdone_d[k] = 1'b1;
              if (dig[k] && !hsig_q[k] && (rdata[k] != CharZero)) begin
                hsig_d[k] = 1'b1;
                sig_d[k]  = cur_q[k];
              end
            end else begin
              sdone_d[k] = 1'b1;
            end
          end
        end
      end
      StDecide: begin
        if (txt_pair) begin
          tmode_d = 1'b1;
          ca_d    = pos_q;
          cnt_d   = (seg_len[0] < seg_len[1]) ? seg_len[0] : seg_len[1];
        end else begin
          tmode_d = 1'b0;
          ca_d    = sig_q;
          cnt_d   = sig_len[0];
          if (!hsig_q[0] && hsig_q[1]) res_d = OrderBefore;
          else if (hsig_q[0] && !hsig_q[1]) res_d = OrderAfter;
          else if (sig_len[0] > sig_len[1]) res_d = OrderAfter;
          else if (sig_len[0] < sig_len[1]) res_d = OrderBefore;
        end
      end
      StCmpAddr: ;
      StCmpData: begin
        if (differ) begin
          res_d = (cx < cy) ? OrderBefore : OrderAfter;
        end
        for (int k = 0; k < 2; k++) ca_d[k] = ca_q[k] + 1'b1;
        cnt_d = cnt_q - 1'b1;
      end
      StPost: begin
        if (tmode_q && (seg_len[0] != seg_len[1])) begin
          res_d = (seg_len[0] < seg_len[1]) ? OrderBefore : OrderAfter;
        end else begin
          // leading zero tie-break, the first one wins
          if (!tmode_q && (hint_q == OrderEqual)) begin
            if (seg_len[0] > seg_len[1]) hint_d = OrderBefore;
            else if (seg_len[0] < seg_len[1]) hint_d = OrderAfter;
          end
          if (both_end) begin
            numeq_d = 1'b1;
            res_d   = (!tmode_q && (hint_q == OrderEqual)) ?
                      ((seg_len[0] > seg_len[1]) ? OrderBefore :
                       (seg_len[0] < seg_len[1]) ? OrderAfter : OrderEqual) : hint_q;
          end else begin
            pos_d   = cur_q;
            first_d = 2'b11;
            hsig_d  = 2'b00;
            sdone_d = 2'b00;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.order             = res_q;
          out_d.numerically_equal = numeq_q;
          out_d.truncated         = ovf_q;
          len_d[0]                = '0;
          len_d[1]                = '0;
          ovf_d                   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q  <= fold_d;
    pos_q   <= pos_d;
    cur_q   <= cur_d;
    sig_q   <= sig_d;
    ca_q    <= ca_d;
    hsig_q  <= hsig_d;
    text_q  <= text_d;
    first_q <= first_d;
    sdone_q <= sdone_d;
    cnt_q   <= cnt_d;
    tmode_q <= tmode_d;
    res_q   <= res_d;
    hint_q  <= hint_d;
    numeq_q <= numeq_d;
    out_q   <= out_d;
  end

endmodule

/* sv/natural_order_string_compare.sv */
// top level of the natural order string compare block
//
// usage: items enter through a queue style port (push/full). an item either
// appends char_code to the first or second string, or asks for a compare,
// which also clears both strings and the truncation flag. unused command
// codes are taken and dropped. each compare gives one result on the
// empty/pop port: order, numerically_equal and truncated.
// the one register, split_at_dots, is written on the cfg port (always ready)
// and is meant to change only while the block is idle.
// an append is handled in the engine's idle state. a compare walks both
// strings through their stores, each character read with an address state
// and then a registered data state: one scan pass per segment plus one
// compare pass, after which the result is handed to the empty/pop port.
// a 4 deep job queue sits in front of the engine, so items are still taken
// while a compare runs or a result waits. when pop stays low the engine
// holds its finished result and stops, the queue fills and full rises.
// reset empties the queue and the result register, clears lengths and the
// flag and sets split_at_dots; string stores are not cleared.
module natural_order_string_compare import nosc_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  // split at dots register
  logic      split_q;
  // job channel between decoder and engine
  job_chan_t job;
  logic      job_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      split_q <= cfg_data_i;
    end
  end

  // decoder and job queue
  nosc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // string stores and compare engine
  nosc_back #(.MaxLen(MaxLen)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .split_i     (split_q),
    .job_i       (job),
    .job_ready_o (job_ready),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

  // order never carries the unused code
  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.order != 2'b10))
    else $error("result order holds an unused code");

  // a result that reports equal order is always numerically equal
  a_equal_numeq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.order == OrderEqual)) |-> out_item_o.numerically_equal)
    else $error("equal order without numerically equal flag");

  // a held result stays put until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before it was taken");

endmodule
